// ===== rtl/rnp_pkg.sv =====
`default_nettype none

package rnp_pkg;

  // widths fixed by the transaction formats
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int OUT_W       = 64;

  // default magnitude range, 2^(VALUE_BITS-1)-1 at most
  localparam int VALUE_BITS_DEF = 64;

  // entries of the classified-character queue
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    K_END   = 3'd0,
    K_BLANK = 3'd1,
    K_MINUS = 3'd2,
    K_DIGIT = 3'd3,
    K_OTHER = 3'd4
  } kind_t;

  // one classified character
  typedef struct packed {
    kind_t               kind;
    logic [DIGIT_W-1:0]  digit;
  } cls_t;

endpackage

`default_nettype wire

// ===== rtl/rnp_char_if.sv =====
`default_nettype none

interface rnp_char_if;
  logic                        valid;
  logic                        ready;
  logic [rnp_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/rnp_result_if.sv =====
`default_nettype none

interface rnp_result_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [rnp_pkg::OUT_W-1:0] value;
  logic signed [rnp_pkg::OUT_W-1:0] largest_value;

  modport source (output valid, output status, output value, output largest_value,
                  input ready);
  modport sink (input valid, input status, input value, input largest_value,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/radix_numeral_parser.sv =====
`default_nettype none

// channel    dir   payload                               transaction
// chars      in    char_code[7:0]                        one character
// results    out   status[1:0], value, largest_value     one line result
// radix_*    in    radix_wdata[5:0]                      write when radix_we
//
// one character per cycle sustained while no line end waits on a stalled result;
// the back end does one multiply-add by the radix per character, and this loop on the magnitude sets the rate
// a line result is loaded into the output register when its line-end character leaves the queue
// synchronous reset clears queue, parser state, running largest value and
// sets the radix to ten
// a stalled result holds back only the next line end; characters ahead of it
// keep flowing, then the two-entry queue fills and the input stalls

module radix_numeral_parser #(
  parameter int VALUE_BITS = rnp_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         radix_we,
  input  logic [rnp_pkg::RADIX_W-1:0]  radix_wdata,
  rnp_char_if.sink                     chars,
  rnp_result_if.source                 results
);

  logic           q_ready;
  logic           q_push;
  rnp_pkg::cls_t  q_in_item;
  logic           q_valid;
  logic           q_pop;
  rnp_pkg::cls_t  q_out_item;

  // classify characters
  rnp_front u_front (
    .chars   (chars),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_item  (q_in_item)
  );

  // decouple front and back
  rnp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out_item)
  );

  // parse and report
  rnp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix_wdata (radix_wdata),
    .q_valid     (q_valid),
    .q_item      (q_out_item),
    .q_pop       (q_pop),
    .results     (results)
  );

endmodule

`default_nettype wire

// ===== rtl/rnp_front.sv =====
`default_nettype none

module rnp_front (
  rnp_char_if.sink        chars,
  input  logic            q_ready,
  output logic            q_push,
  output rnp_pkg::cls_t   q_item
);

  // accept whenever the queue has room
  assign chars.ready = q_ready;
  assign q_push      = chars.valid && q_ready;

  // classify the character
  always_comb begin
    q_item.kind  = rnp_pkg::K_OTHER;
    q_item.digit = '0;
    if (chars.char_code == rnp_pkg::CH_NL || chars.char_code == rnp_pkg::CH_NUL) begin
      q_item.kind = rnp_pkg::K_END;
    end else if (chars.char_code == rnp_pkg::CH_SPACE ||
                 chars.char_code == rnp_pkg::CH_TAB) begin
      q_item.kind = rnp_pkg::K_BLANK;
    end else if (chars.char_code == rnp_pkg::CH_MINUS) begin
      q_item.kind = rnp_pkg::K_MINUS;
    end else if (chars.char_code inside {[rnp_pkg::CH_ZERO:rnp_pkg::CH_NINE]}) begin
      q_item.kind  = rnp_pkg::K_DIGIT;
      q_item.digit = rnp_pkg::DIGIT_W'(chars.char_code - rnp_pkg::CH_ZERO);
    end else if (chars.char_code inside {[rnp_pkg::CH_A:rnp_pkg::CH_Z]}) begin
      q_item.kind  = rnp_pkg::K_DIGIT;
      q_item.digit = rnp_pkg::DIGIT_W'(chars.char_code - rnp_pkg::CH_A
                                       + rnp_pkg::LETTER_OFFSET);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rnp_queue.sv =====
`default_nettype none

module rnp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rnp_pkg::cls_t  push_item,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output rnp_pkg::cls_t  pop_item
);

  localparam int PTR_W = $clog2(rnp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rnp_pkg::QUEUE_DEPTH + 1);

  rnp_pkg::cls_t     mem [rnp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign push_ready = (count != CNT_W'(rnp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(rnp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(rnp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rnp_back.sv =====
`default_nettype none

module rnp_back #(
  parameter int VALUE_BITS = rnp_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         radix_we,
  input  logic [rnp_pkg::RADIX_W-1:0]  radix_wdata,
  input  logic                         q_valid,
  input  rnp_pkg::cls_t                q_item,
  output logic                         q_pop,
  rnp_result_if.source                 results
);

  localparam int MAG_W  = VALUE_BITS - 1;
  localparam int PROD_W = MAG_W + rnp_pkg::RADIX_W + 1;
  localparam int OUT_W  = rnp_pkg::OUT_W;

  logic [rnp_pkg::RADIX_W-1:0] radix;

  rnp_pkg::phase_t   phase, phase_next;
  logic [MAG_W-1:0]  magnitude, magnitude_next;
  logic              negative, negative_next;
  rnp_pkg::status_t  pending_error, pending_error_next;
  logic [OUT_W-1:0]  largest_seen, largest_seen_next;

  logic              out_valid;
  rnp_pkg::status_t  out_status;
  logic [OUT_W-1:0]  out_value;
  logic [OUT_W-1:0]  out_largest;

  logic              is_end;
  logic              emit;
  rnp_pkg::status_t  emit_status;
  logic [OUT_W-1:0]  emit_value;
  logic [PROD_W-1:0] prod;
  logic              overflow;
  logic              bad_digit;
  logic [OUT_W-1:0]  mag_ext;
  logic [OUT_W-1:0]  signed_mag;
  logic [OUT_W-1:0]  largest_abs;

  // line ends need room in the output register, other characters never stall
  assign is_end = (q_item.kind == rnp_pkg::K_END);
  assign q_pop  = q_valid && (!is_end || !out_valid || results.ready);
  assign emit   = q_pop && is_end;

  // one multiply-add by the radix
  assign prod      = PROD_W'(magnitude) * PROD_W'(radix) + PROD_W'(q_item.digit);
  assign overflow  = (prod[PROD_W-1:MAG_W] != '0);
  assign bad_digit = (q_item.kind != rnp_pkg::K_DIGIT) ||
                     (q_item.digit >= radix);

  assign mag_ext     = {{(OUT_W-MAG_W){1'b0}}, magnitude};
  assign signed_mag  = negative ? (~mag_ext + 1'b1) : mag_ext;
  assign largest_abs = largest_seen[OUT_W-1] ? (~largest_seen + 1'b1) : largest_seen;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rnp_pkg::RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rnp_pkg::PH_LEAD;
      magnitude     <= '0;
      negative      <= 1'b0;
      pending_error <= rnp_pkg::ST_OK;
      largest_seen  <= '0;
    end else begin
      phase         <= phase_next;
      magnitude     <= magnitude_next;
      negative      <= negative_next;
      pending_error <= pending_error_next;
      largest_seen  <= largest_seen_next;
    end
  end

  // next state and line result
  always_comb begin
    phase_next         = phase;
    magnitude_next     = magnitude;
    negative_next      = negative;
    pending_error_next = pending_error;
    largest_seen_next  = largest_seen;
    emit_status        = rnp_pkg::ST_OK;
    emit_value         = '0;
    if (q_pop) begin
      if (is_end) begin
        case (phase)
          rnp_pkg::PH_SKIP: begin
            emit_status = pending_error;
          end
          rnp_pkg::PH_LEAD, rnp_pkg::PH_SIGN: begin
            emit_status = rnp_pkg::ST_EMPTY;
          end
          default: begin
            emit_status = rnp_pkg::ST_OK;
            emit_value  = signed_mag;
            if (mag_ext > largest_abs) begin
              largest_seen_next = signed_mag;
            end
          end
        endcase
        phase_next         = rnp_pkg::PH_LEAD;
        magnitude_next     = '0;
        negative_next      = 1'b0;
        pending_error_next = rnp_pkg::ST_OK;
      end else if (phase == rnp_pkg::PH_SKIP) begin
        // ignore until line end
      end else if (phase == rnp_pkg::PH_LEAD && q_item.kind == rnp_pkg::K_BLANK) begin
        // skip leading blank
      end else if (phase == rnp_pkg::PH_LEAD && q_item.kind == rnp_pkg::K_MINUS) begin
        negative_next = 1'b1;
        phase_next    = rnp_pkg::PH_SIGN;
      end else if (phase == rnp_pkg::PH_SIGN && q_item.kind == rnp_pkg::K_BLANK) begin
        pending_error_next = rnp_pkg::ST_EMPTY;
        phase_next         = rnp_pkg::PH_SKIP;
      end else if (bad_digit) begin
        pending_error_next = rnp_pkg::ST_INVALID;
        phase_next         = rnp_pkg::PH_SKIP;
      end else if (overflow) begin
        pending_error_next = rnp_pkg::ST_OVERFLOW;
        phase_next         = rnp_pkg::PH_SKIP;
      end else begin
        magnitude_next = prod[MAG_W-1:0];
        phase_next     = rnp_pkg::PH_DIGITS;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status  <= emit_status;
      out_value   <= emit_value;
      out_largest <= largest_seen_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.status        = out_status;
  assign results.value         = out_value;
  assign results.largest_value = out_largest;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  import rnp_pkg::*;

  localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_BITS_DEF - 1)) - 64'd1;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam int PHASE_CHARS = 160;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // one line result as seen on the result channel
  typedef struct packed {
    status_t     st;
    logic [63:0] val;
    logic [63:0] largest;
  } line_result_t;

  // directed line: body text (first character in the highest used byte) and terminator
  typedef struct packed {
    logic [31:0]  text;
    logic [2:0]   len;
    logic [7:0]   term;
    logic         typed;
    line_result_t res;
  } line_row_t;

  localparam int NUM_ROWS = 11;
  localparam line_row_t LINE_ROWS [NUM_ROWS] = '{
    '{32'h0,              3'd0, CH_NL,  1'b1, '{ST_EMPTY,   64'd0,   64'd0}},
    '{32'h0,              3'd0, CH_NUL, 1'b1, '{ST_EMPTY,   64'd0,   64'd0}},
    '{" \t-7",            3'd4, CH_NL,  1'b1, '{ST_OK,      -64'sd7, -64'sd7}},
    '{"-",                3'd1, CH_NL,  1'b1, '{ST_EMPTY,   64'd0,   -64'sd7}},
    '{"- ",               3'd2, CH_NL,  1'b1, '{ST_EMPTY,   64'd0,   -64'sd7}},
    '{"7 ",               3'd2, CH_NUL, 1'b1, '{ST_INVALID, 64'd0,   -64'sd7}},
    '{"--",               3'd2, CH_NL,  1'b1, '{ST_INVALID, 64'd0,   -64'sd7}},
    '{"-0",               3'd2, CH_NL,  1'b1, '{ST_OK,      64'd0,   -64'sd7}},
    '{"7",                3'd1, CH_NL,  1'b0, '{ST_OK,      64'd0,   64'd0}},
    '{{CH_LOWER_A, 8'hFF}, 3'd2, CH_NL, 1'b1, '{ST_INVALID, 64'd0,   -64'sd7}},
    '{"A",                3'd1, CH_NL,  1'b1, '{ST_INVALID, 64'd0,   -64'sd7}}
  };

  localparam int NUM_RADIXES = 10;
  localparam logic [RADIX_W-1:0] RADIX_PLAN [NUM_RADIXES] = '{
    6'd2, 6'd36, 6'd16, 6'd8, 6'd0, 6'd1, 6'd63, 6'd37, 6'd3, 6'd10
  };

  logic clk;
  logic rst;
  logic radix_we;
  logic [RADIX_W-1:0] radix_wdata;

  rnp_char_if chars_if();
  rnp_result_if results_if();

  radix_numeral_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix_wdata (radix_wdata),
    .chars       (chars_if),
    .results     (results_if)
  );

  // parser state mirror
  phase_t             line_phase;
  logic [63:0]        acc_mag;
  bit                 acc_neg;
  status_t            held_err;
  logic [63:0]        best_val;
  logic [RADIX_W-1:0] cur_radix;

  line_result_t expected_lines [$];
  int  mismatches = 0;
  int  chars_sent = 0;
  int  hold_requests = 0;
  bit  quiet = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [63:0] mag_of(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 64'(c - CH_ZERO);
    if (c >= CH_A && c <= CH_Z) return 64'(c - CH_A) + 64'(LETTER_OFFSET);
    return 64'd255;
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    return (d < 10) ? 8'(CH_ZERO + d) : 8'(CH_A + (d - 10));
  endfunction

  function automatic void start_line();
    line_phase = PH_LEAD;
    acc_mag = '0;
    acc_neg = 1'b0;
    held_err = ST_OK;
  endfunction

  // advance the parser mirror by one character; returns 1 when a line result is due
  function automatic bit parse_char(input logic [7:0] c, output line_result_t res);
    bit is_end;
    bit is_blank;
    logic [63:0] d;
    res = '0;
    is_end = (c == CH_NL) || (c == CH_NUL);
    is_blank = (c == CH_SPACE) || (c == CH_TAB);

    // line end closes the line
    if (is_end) begin
      if (line_phase == PH_SKIP) begin
        res.st = held_err;
      end else if (line_phase == PH_LEAD || line_phase == PH_SIGN) begin
        res.st = ST_EMPTY;
      end else begin
        res.st = ST_OK;
        res.val = acc_neg ? -acc_mag : acc_mag;
        if (acc_mag > mag_of(best_val)) best_val = res.val;
      end
      res.largest = best_val;
      start_line();
      return 1'b1;
    end

    // blanks and sign before the first digit
    case (line_phase)
      PH_LEAD: begin
        if (is_blank) return 1'b0;
        if (c == CH_MINUS) begin
          acc_neg = 1'b1;
          line_phase = PH_SIGN;
          return 1'b0;
        end
      end
      PH_SIGN: begin
        if (is_blank) begin
          held_err = ST_EMPTY;
          line_phase = PH_SKIP;
          return 1'b0;
        end
      end
      PH_SKIP: return 1'b0;
      default: ;
    endcase

    // digit accumulate with overflow guard
    d = digit_value(c);
    line_phase = PH_DIGITS;
    if (d >= 64'(cur_radix)) begin
      held_err = ST_INVALID;
      line_phase = PH_SKIP;
    end else if (acc_mag > (MAG_LIMIT - d) / 64'(cur_radix)) begin
      held_err = ST_OVERFLOW;
      line_phase = PH_SKIP;
    end else begin
      acc_mag = acc_mag * 64'(cur_radix) + d;
    end
    return 1'b0;
  endfunction

  // idle length for either side: mostly none, some short, a few long
  function automatic int pick_idle();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one character, predict its effect, wait for the transaction
  task automatic send_char(input logic [7:0] c, input bit typed, input line_result_t typed_res);
    line_result_t res;
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (parse_char(c, res)) expected_lines.push_back(typed ? typed_res : res);
    chars_sent++;
    chars_if.valid <= 1'b1;
    chars_if.char_code <= c;
    do @(posedge clk); while (!chars_if.ready);
  endtask

  task automatic drain_results();
    chars_if.valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain_results();
    radix_we <= 1'b1;
    radix_wdata <= r;
    @(posedge clk);
    radix_we <= 1'b0;
    cur_radix = r;
  endtask

  function automatic logic [63:0] pick_magnitude();
    case ($urandom_range(0, 7))
      0: return MAG_LIMIT;
      1: return MAG_LIMIT - 64'($urandom_range(1, 5));
      2: return MAG_LIMIT + 64'd1;
      3: return MAG_LIMIT + 64'd1 + 64'($urandom);
      4: return '1;
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 5))
      0: return 8'(CH_ZERO + $urandom_range(0, 9));
      1: return 8'(CH_A + $urandom_range(0, 25));
      2: return 8'(CH_LOWER_A + $urandom_range(0, 25));
      3: return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
      4: return CH_MINUS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one random line: mostly well-formed numbers, some broken ones, some noise
  task automatic send_random_line();
    logic [7:0] line_q [$];
    logic [7:0] digits_q [$];
    logic [63:0] m;
    int lim;
    int kind;
    int n;
    lim = (cur_radix == 0) ? 2 : ((cur_radix > 36) ? 36 : int'(cur_radix));
    kind = $urandom_range(0, 99);

    if (kind < 85) begin
      // leading blanks and sign
      repeat ($urandom_range(0, 2)) line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      if ($urandom_range(0, 1)) line_q.push_back(CH_MINUS);
      if (kind >= 45 && kind < 70) begin
        // large magnitudes near the signed limit
        if (cur_radix >= 2 && cur_radix <= 36) begin
          m = pick_magnitude();
          do begin
            digits_q.push_front(digit_char(int'(m % 64'(cur_radix))));
            m = m / 64'(cur_radix);
          end while (m != 0);
          line_q = {line_q, digits_q};
        end else begin
          repeat ($urandom_range(10, 70)) line_q.push_back(digit_char($urandom_range(0, lim - 1)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) line_q.push_back(digit_char($urandom_range(0, lim - 1)));
      end
      // broken sequence: an odd character inserted anywhere in the line
      if (kind >= 70) begin
        line_q.insert($urandom_range(0, line_q.size()), odd_char());
        repeat ($urandom_range(0, 2)) line_q.push_back(digit_char($urandom_range(0, lim - 1)));
      end
    end else begin
      // noise
      n = $urandom_range(0, 8);
      repeat (n) line_q.push_back(odd_char());
    end
    line_q.push_back(($urandom_range(0, 4) == 0) ? CH_NUL : CH_NL);

    foreach (line_q[i]) send_char(line_q[i], 1'b0, '0);
  endtask

  // result side: random stalls, long hold on request, compare each transaction
  initial begin : result_sink
    int stall_left;
    int holds_done;
    line_result_t want;
    stall_left = 0;
    holds_done = 0;
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (results_if.valid && results_if.ready) begin
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected line result: status %0d value %0d largest %0d",
                     results_if.status, results_if.value, results_if.largest_value);
        end else begin
          want = expected_lines.pop_front();
          if (results_if.status !== want.st || results_if.value !== want.val ||
              results_if.largest_value !== want.largest) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("line result mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       want.st, $signed(want.val), $signed(want.largest),
                       results_if.status, results_if.value, results_if.largest_value);
          end
        end
      end
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        results_if.ready <= 1'b0;
        stall_left--;
      end else begin
        results_if.ready <= 1'b1;
        stall_left = pick_idle();
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int phase_start;
    rst = 1'b1;
    radix_we = 1'b0;
    radix_wdata = '0;
    chars_if.valid = 1'b0;
    chars_if.char_code = '0;
    cur_radix = RADIX_RESET;
    best_val = '0;
    start_line();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed lines at the reset radix
    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int k = int'(LINE_ROWS[i].len) - 1; k >= 0; k--)
        send_char(LINE_ROWS[i].text[k*8 +: 8], 1'b0, '0);
      send_char(LINE_ROWS[i].term, LINE_ROWS[i].typed, LINE_ROWS[i].res);
    end

    // random lines over a series of radix settings
    for (int p = 0; p < NUM_RADIXES; p++) begin
      write_radix(RADIX_PLAN[p]);
      quiet = (p == 2);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) send_random_line();

      // back-pressure: result side holds off while short lines keep coming
      if (p == 3) begin
        hold_requests++;
        repeat (40) begin
          send_char(8'(CH_ZERO + $urandom_range(0, 7)), 1'b0, '0);
          send_char(CH_NL, 1'b0, '0);
        end
        drain_results();
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
